### rtl/assert_macros.svh
// Assertion macros used by the encoder turn sequencer
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/ets_pkg.sv
// Package: types and constants for the encoder turn sequencer
`default_nettype none

package ets_pkg;

    localparam int COUNT_BITS_DEF = 16;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 32;

    localparam logic [7:0]  DUTY_MAX          = 8'd255;
    localparam logic [15:0] STALL_INTERVAL_RST = 16'd300;
    localparam logic [7:0]  DUTY_STEP_RST     = 8'd15;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_TURN    = 2'd1,
        PH_DONE    = 2'd2,
        PH_TIMEOUT = 2'd3
    } t_phase;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_TARGET_PULSES  = 3'd0,
        REG_TIMEOUT_LIMIT  = 3'd1,
        REG_START_DUTY     = 3'd2,
        REG_CLOCKWISE      = 3'd3,
        REG_STALL_INTERVAL = 3'd4,
        REG_DUTY_STEP      = 3'd5
    } t_cfg_reg;

endpackage

`default_nettype wire

### rtl/encoder_turn_sequencer.sv
// Encoder turn sequencer: in-place turn of a two-wheel drive
// Input channel (i_in_valid / o_in_ready): i_cmd = 1 starts a turn, i_cmd = 0 is a
// one millisecond tick carrying both encoder counts.
// Output channel (o_out_valid / i_out_ready): one transaction per input transaction,
// in order, holding both signed wheel duties, the status and the counter clear.
// The result register is loaded at the edge that accepts the input. Throughput is one
// transaction per cycle while the receiver does not stall; all tick work is one compare
// and count pass through the state registers. Direction is sampled when a result forms.
// When the receiver stalls, the result register holds and o_in_ready drops until
// the waiting result is taken; a result taken in the same cycle frees room at once.
// Configuration is a plain write port (i_cfg_wr_en, i_cfg_index, i_cfg_data), which the
// user writes only while no transaction is in flight; the block does not enforce this.
// Synchronous active-low reset returns the phase to idle, clears the counters and
// duty, and loads the register defaults (clockwise, stall interval 300, step 15).
`default_nettype none
`include "assert_macros.svh"

module encoder_turn_sequencer #(
    parameter int COUNT_BITS = ets_pkg::COUNT_BITS_DEF
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    // configuration
    input  wire                                  i_cfg_wr_en,
    input  wire  [ets_pkg::CFG_INDEX_BITS-1:0]   i_cfg_index,
    input  wire  [ets_pkg::CFG_DATA_BITS-1:0]    i_cfg_data,
    // input channel
    input  wire                                  i_in_valid,
    output logic                                 o_in_ready,
    input  wire                                  i_cmd,
    input  wire  [15:0]                          i_left_count,
    input  wire  [15:0]                          i_right_count,
    // output channel
    output logic                                 o_out_valid,
    input  wire                                  i_out_ready,
    output logic signed [8:0]                    o_left_drive,
    output logic signed [8:0]                    o_right_drive,
    output logic [1:0]                           o_status,
    output logic                                 o_clear_counts
);

    // counts above 16 bits add nothing since the fields are 16 bits wide
    localparam int PULSE_BITS = (COUNT_BITS < 16) ? COUNT_BITS : 16;

    // configuration registers
    logic [15:0] r_target_pulses;
    logic [31:0] r_timeout_limit;
    logic [7:0]  r_start_duty;
    logic        r_clockwise;
    logic [15:0] r_stall_interval;
    logic [7:0]  r_duty_step;

    // turn state
    ets_pkg::t_phase         r_phase, n_phase;
    logic [31:0]             r_elapsed, n_elapsed;
    logic [15:0]             r_ticks, n_ticks;
    logic [PULSE_BITS-1:0]   r_pulses_at_check, n_pulses_at_check;
    logic [7:0]              r_duty, n_duty;

    // result register
    logic                    r_out_valid;
    logic signed [8:0]       r_left_drive, n_left_drive;
    logic signed [8:0]       r_right_drive, n_right_drive;
    logic [1:0]              r_status;
    logic                    r_clear_counts;

    logic                    in_acc;
    logic [PULSE_BITS-1:0]   left_m, right_m, pulses;
    logic [15:0]             pulses_ext;
    logic [31:0]             elapsed_inc;
    logic [15:0]             ticks_inc;
    logic [8:0]              duty_sum;
    logic [8:0]              duty_mag;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_acc     = i_in_valid && o_in_ready;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_pulses  <= '0;
            r_timeout_limit  <= '0;
            r_start_duty     <= '0;
            r_clockwise      <= 1'b1;
            r_stall_interval <= ets_pkg::STALL_INTERVAL_RST;
            r_duty_step      <= ets_pkg::DUTY_STEP_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                ets_pkg::REG_TARGET_PULSES:  r_target_pulses  <= i_cfg_data[15:0];
                ets_pkg::REG_TIMEOUT_LIMIT:  r_timeout_limit  <= i_cfg_data[31:0];
                ets_pkg::REG_START_DUTY:     r_start_duty     <= i_cfg_data[7:0];
                ets_pkg::REG_CLOCKWISE:      r_clockwise      <= i_cfg_data[0];
                ets_pkg::REG_STALL_INTERVAL: r_stall_interval <= i_cfg_data[15:0];
                ets_pkg::REG_DUTY_STEP:      r_duty_step      <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // next state for one transaction
    always_comb begin
        left_m      = i_left_count[PULSE_BITS-1:0];
        right_m     = i_right_count[PULSE_BITS-1:0];
        pulses      = (left_m > right_m) ? left_m : right_m;
        pulses_ext  = 16'(pulses);
        elapsed_inc = (r_elapsed == '1) ? r_elapsed : r_elapsed + 32'd1;
        ticks_inc   = (r_ticks == '1) ? r_ticks : r_ticks + 16'd1;
        duty_sum    = {1'b0, r_duty} + {1'b0, r_duty_step};

        n_phase           = r_phase;
        n_elapsed         = r_elapsed;
        n_ticks           = r_ticks;
        n_pulses_at_check = r_pulses_at_check;
        n_duty            = r_duty;

        if (i_cmd) begin
            n_elapsed         = '0;
            n_ticks           = '0;
            n_pulses_at_check = '0;
            n_duty            = r_start_duty;
            n_phase = (r_target_pulses == '0) ? ets_pkg::PH_DONE : ets_pkg::PH_TURN;
        end else if (r_phase == ets_pkg::PH_TURN) begin
            n_elapsed = elapsed_inc;
            if (elapsed_inc > r_timeout_limit) begin
                n_phase = ets_pkg::PH_TIMEOUT;
            end else if (pulses_ext >= r_target_pulses) begin
                n_phase = ets_pkg::PH_DONE;
            end else begin
                n_ticks = ticks_inc;
                // stall check; an interval of zero fires every tick
                if (ticks_inc >= r_stall_interval) begin
                    if (pulses <= r_pulses_at_check && r_duty < ets_pkg::DUTY_MAX) begin
                        n_duty = (duty_sum > {1'b0, ets_pkg::DUTY_MAX}) ?
                                 ets_pkg::DUTY_MAX : duty_sum[7:0];
                    end
                    n_pulses_at_check = pulses;
                    n_ticks           = '0;
                end
            end
        end

        duty_mag      = (n_phase == ets_pkg::PH_TURN) ? {1'b0, n_duty} : 9'd0;
        n_left_drive  = r_clockwise ? duty_mag : 9'd0 - duty_mag;
        n_right_drive = r_clockwise ? 9'd0 - duty_mag : duty_mag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase           <= ets_pkg::PH_IDLE;
            r_elapsed         <= '0;
            r_ticks           <= '0;
            r_pulses_at_check <= '0;
            r_duty            <= '0;
        end else if (in_acc) begin
            r_phase           <= n_phase;
            r_elapsed         <= n_elapsed;
            r_ticks           <= n_ticks;
            r_pulses_at_check <= n_pulses_at_check;
            r_duty            <= n_duty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_left_drive   <= n_left_drive;
            r_right_drive  <= n_right_drive;
            r_status       <= n_phase;
            r_clear_counts <= i_cmd;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_left_drive   = r_left_drive;
    assign o_right_drive  = r_right_drive;
    assign o_status       = r_status;
    assign o_clear_counts = r_clear_counts;

    `ASSERT_NEXT(a_start_clears, i_clk, i_rst_n, in_acc && i_cmd,
        o_out_valid && o_clear_counts, "start transaction did not request a count clear")
    `ASSERT_IMPL(a_stopped_drives_zero, i_clk, i_rst_n,
        o_out_valid && o_status != ets_pkg::PH_TURN,
        o_left_drive == 9'sd0 && o_right_drive == 9'sd0, "drives not zero outside a turn")
    `ASSERT_NEXT(a_duty_monotonic, i_clk, i_rst_n,
        in_acc && !i_cmd && r_phase == ets_pkg::PH_TURN,
        r_duty >= $past(r_duty), "duty fell during a turn")
    `ASSERT_NEXT(a_done_holds, i_clk, i_rst_n,
        r_phase == ets_pkg::PH_DONE && !(in_acc && i_cmd),
        r_phase == ets_pkg::PH_DONE, "finished turn left its phase without a start")

endmodule

`default_nettype wire
